@@ rtl/core/rnt_pkg.sv @@
// rnt_pkg: shared types, constants and the control store for radix_number_to_text.
// No dependencies; imported by the sequencer, the datapath and the top level.

package rnt_pkg;

  localparam logic [4:0] BASE_MIN   = 5'd2;
  localparam logic [4:0] BASE_MAX   = 5'd16;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_NONE  = 8'h00;
  localparam int         DIV_BITS   = 8;     // dividend bits retired per divide cycle

  // datapath operation of one control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_STORE,
    OP_PUT_SIGN,
    OP_READ,
    OP_PUT_DIGIT,
    OP_PUT_ERR
  } op_t;

  // jump condition of one control word
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_BAD,
    C_CHUNK_MORE,
    C_Q_NONZERO,
    C_NO_SIGN,
    C_OUT_BUSY,
    C_DIGITS_LEFT
  } cond_t;

  typedef logic [3:0] upc_t;

  localparam upc_t S_IDLE     = 4'd0;
  localparam upc_t S_CHECK    = 4'd1;
  localparam upc_t S_DSTART   = 4'd2;
  localparam upc_t S_DSTEP    = 4'd3;
  localparam upc_t S_STORE    = 4'd4;
  localparam upc_t S_SIGN_CHK = 4'd5;
  localparam upc_t S_PUT_SIGN = 4'd6;
  localparam upc_t S_READ     = 4'd7;
  localparam upc_t S_PUT_DIG  = 4'd8;
  localparam upc_t S_MORE     = 4'd9;
  localparam upc_t S_DONE     = 4'd10;
  localparam upc_t S_ERR      = 4'd11;
  localparam upc_t S_ERR_DONE = 4'd12;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic fire;
    logic bad;
    logic chunk_more;
    logic q_nonzero;
    logic neg;
    logic digits_left;
    logic out_busy;
  } status_t;

  // control store: a taken condition jumps to target, otherwise fall through
  function automatic uword_t ucode(input upc_t s);
    uword_t w;
    w = '{accept: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    case (s)
      S_IDLE:     w = '{1'b1, OP_LOAD,      C_NO_REQ,      S_IDLE};
      S_CHECK:    w = '{1'b0, OP_NONE,      C_BAD,         S_ERR};
      S_DSTART:   w = '{1'b0, OP_DIV_START, C_NEVER,       S_IDLE};
      S_DSTEP:    w = '{1'b0, OP_DIV_STEP,  C_CHUNK_MORE,  S_DSTEP};
      S_STORE:    w = '{1'b0, OP_STORE,     C_Q_NONZERO,   S_DSTART};
      S_SIGN_CHK: w = '{1'b0, OP_NONE,      C_NO_SIGN,     S_READ};
      S_PUT_SIGN: w = '{1'b0, OP_PUT_SIGN,  C_OUT_BUSY,    S_PUT_SIGN};
      S_READ:     w = '{1'b0, OP_READ,      C_NEVER,       S_IDLE};
      S_PUT_DIG:  w = '{1'b0, OP_PUT_DIGIT, C_OUT_BUSY,    S_PUT_DIG};
      S_MORE:     w = '{1'b0, OP_NONE,      C_DIGITS_LEFT, S_READ};
      S_DONE:     w = '{1'b0, OP_NONE,      C_ALWAYS,      S_IDLE};
      S_ERR:      w = '{1'b0, OP_PUT_ERR,   C_OUT_BUSY,    S_ERR};
      S_ERR_DONE: w = '{1'b0, OP_NONE,      C_ALWAYS,      S_IDLE};
      default:    w = '{1'b0, OP_NONE,      C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else if (lower) begin
      c = CHAR_LO_A + {4'd0, d - 4'd10};
    end else begin
      c = CHAR_UP_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

@@ rtl/core/rnt_ram.sv @@
// rnt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module rnt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/rnt_sequencer.sv @@
// rnt_sequencer: step counter over the control store in rnt_pkg, with conditional jumps.
// Depends on rnt_pkg; takes datapath status, drives the current control word.

module rnt_sequencer import rnt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output uword_t  uword
);

  upc_t step;
  upc_t step_next;
  logic take;

  assign uword = ucode(step);

  always_comb begin
    case (uword.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_REQ:      take = !status.fire;
      C_BAD:         take = status.bad;
      C_CHUNK_MORE:  take = status.chunk_more;
      C_Q_NONZERO:   take = status.q_nonzero;
      C_NO_SIGN:     take = !status.neg;
      C_OUT_BUSY:    take = status.out_busy;
      C_DIGITS_LEFT: take = status.digits_left;
      default:       take = 1'b1;
    endcase
    step_next = take ? uword.target : step + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  a_req_to_check: assert property (@(posedge clk) disable iff (rst)
    status.fire |=> step == S_CHECK)
    else $error("accepted request did not advance to base check");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    uword.accept |-> step == S_IDLE)
    else $error("request taken outside idle step");

endmodule

@@ rtl/core/rnt_datapath.sv @@
// rnt_datapath: operand registers, 8-bit-per-cycle divider, digit RAM and output register.
// Depends on rnt_pkg and rnt_ram; steered by the control word from rnt_sequencer.

module rnt_datapath import rnt_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uword_t                uword,
  output status_t               status,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [4:0]            base,
  input  logic                  unsigned_mode,
  input  logic                  lowercase,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            char_code,
  output logic                  last,
  output logic                  bad_base
);

  localparam int NCHUNK  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int Q_W     = NCHUNK * DIV_BITS;
  localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W  = $clog2(VALUE_BITS);

  logic                  fire;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag;
  logic [Q_W-1:0]        quot;
  logic [4:0]            base_r;
  logic                  lower_r;
  logic                  neg;
  logic [3:0]            rem;
  logic [3:0]            rem_next;
  logic [DIV_BITS-1:0]   qbits;
  logic [CHUNK_W-1:0]    chunk;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_dec;
  logic                  out_free;
  logic                  put;
  logic                  store_ok;
  logic [3:0]            rd_digit;

  assign fire     = in_valid && uword.accept;
  assign neg_in   = !unsigned_mode && value[VALUE_BITS-1];
  assign mag      = neg_in ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
  assign out_free = !out_valid || out_ready;
  assign put      = out_free && (uword.op == OP_PUT_SIGN || uword.op == OP_PUT_DIGIT ||
                                 uword.op == OP_PUT_ERR);
  assign count_dec = count - {{(CNT_W-1){1'b0}}, 1'b1};
  assign store_ok  = (uword.op == OP_STORE) && (count < CNT_W'(VALUE_BITS));

  // restoring long division, DIV_BITS dividend bits per cycle, MSB first
  always_comb begin
    logic [4:0] t;
    logic [3:0] r;
    r = rem;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, quot[Q_W-1-i]};
      if (t >= base_r) begin
        qbits[DIV_BITS-1-i] = 1'b1;
        r = 4'(t - base_r);
      end else begin
        r = t[3:0];
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      neg   <= 1'b0;
      quot  <= '0;
    end else begin
      case (uword.op)
        OP_LOAD: begin
          if (fire) begin
            quot    <= Q_W'(mag);
            base_r  <= base;
            lower_r <= lowercase;
            neg     <= neg_in;
            count   <= '0;
          end
        end
        OP_DIV_START: begin
          rem   <= '0;
          chunk <= '0;
        end
        OP_DIV_STEP: begin
          rem   <= rem_next;
          quot  <= (quot << DIV_BITS) | Q_W'(qbits);
          chunk <= chunk + {{(CHUNK_W-1){1'b0}}, 1'b1};
        end
        OP_STORE: begin
          if (store_ok) begin
            count <= count + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
        OP_PUT_DIGIT: begin
          if (out_free) begin
            count <= count_dec;
          end
        end
        OP_PUT_ERR: begin
          quot <= '0;
          neg  <= 1'b0;
          count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  rnt_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (store_ok),
    .waddr (count[ADDR_W-1:0]),
    .wdata (rem),
    .re    (uword.op == OP_READ),
    .raddr (count_dec[ADDR_W-1:0]),
    .rdata (rd_digit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      case (uword.op)
        OP_PUT_SIGN: begin
          char_code <= CHAR_MINUS;
          last      <= 1'b0;
          bad_base  <= 1'b0;
        end
        OP_PUT_DIGIT: begin
          char_code <= digit_char(rd_digit, lower_r);
          last      <= (count == {{(CNT_W-1){1'b0}}, 1'b1});
          bad_base  <= 1'b0;
        end
        default: begin
          char_code <= CHAR_NONE;
          last      <= 1'b1;
          bad_base  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    status.fire        = fire;
    status.bad         = (base_r < BASE_MIN) || (base_r > BASE_MAX);
    status.chunk_more  = (chunk != CHUNK_W'(NCHUNK - 1));
    status.q_nonzero   = (quot != '0);
    status.neg         = neg;
    status.digits_left = (count != '0);
    status.out_busy    = !out_free;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond store depth");

  a_digit_present: assert property (@(posedge clk) disable iff (rst)
    (uword.op == OP_PUT_DIGIT || uword.op == OP_READ) |-> count != '0)
    else $error("digit emitted with none stored");

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_base |-> last && char_code == CHAR_NONE)
    else $error("error result malformed");

endmodule

@@ rtl/core/radix_number_to_text.sv @@
// radix_number_to_text: top level, integer to ASCII text in base 2..16.
// Depends on rnt_pkg, rnt_sequencer, rnt_datapath (and rnt_ram below it).
//
// Usage: one request on in_valid/in_ready carries value, base, unsigned_mode
// and lowercase. The block answers with a string of characters on
// out_valid/out_ready: an optional '-', then the digits most significant
// first; last marks the final character. A base outside 2..16 yields a
// single result with char_code 0, last 1 and bad_base 1.
// Timing: a request is taken only in the idle step. Each digit is a divide
// start, divide steps over the value in 8-bit chunks and a store (the shared
// divider retires 8 dividend bits per cycle); the sign is an output load;
// each character is a digit RAM read, an output load and a loop test; each
// request also takes a load, a base check, a sign test and a return.
// Reset clears the step counter, digit count and output valid; the block
// then waits in idle. A stalled receiver holds the output register and the
// sequencer waits on it; the last character can still sit there while the
// next request is taken.

module radix_number_to_text import rnt_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [4:0]            base,
  input  logic                  unsigned_mode,
  input  logic                  lowercase,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            char_code,
  output logic                  last,
  output logic                  bad_base
);

  uword_t  uword;
  status_t status;

  assign in_ready = uword.accept;

  rnt_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  rnt_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .uword         (uword),
    .status        (status),
    .in_valid      (in_valid),
    .value         (value),
    .base          (base),
    .unsigned_mode (unsigned_mode),
    .lowercase     (lowercase),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_code     (char_code),
    .last          (last),
    .bad_base      (bad_base)
  );

endmodule

@@ tb/sv/radix_number_to_text_test.sv @@
`timescale 1ns / 100ps
// radix_number_to_text_test: self-checking bench for radix_number_to_text.
// Needs rnt_pkg and the block; predicts each character and checks it in order.

module radix_number_to_text_test;
  import rnt_pkg::*;

  localparam int VALUE_BITS = 48;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [4:0]            base;
    bit                    uns;
    bit                    lower;
    int                    send_idle;
    int                    recv_idle;
    bit                    drain_first;
  } number_req_t;

  typedef struct {
    logic [7:0] code;
    logic       is_last;
    logic       is_bad;
  } text_char_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value;
  logic [4:0]            base;
  logic                  unsigned_mode;
  logic                  lowercase;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            char_code;
  logic                  last;
  logic                  bad_base;

  number_req_t pending_reqs[$];
  text_char_t  expected_text[$];
  int          fail_count = 0;
  bit          request_taken = 1'b0;
  int          recv_idle_pct = 0;
  int          phase_send = 31;
  int          phase_recv = 53;

  // predictor state
  logic [3:0]            digit_mem[VALUE_BITS];
  int                    digit_total = 0;
  bit                    sign_flag = 1'b0;
  logic [VALUE_BITS-1:0] quot_state = '0;

  radix_number_to_text #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .value(value), .base(base), .unsigned_mode(unsigned_mode), .lowercase(lowercase),
    .out_valid(out_valid), .out_ready(out_ready),
    .char_code(char_code), .last(last), .bad_base(bad_base)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // expected characters of one request, appended to expected_text
  task automatic predict_text(input logic [VALUE_BITS-1:0] raw, input logic [4:0] radix,
                              input bit uns, input bit lower);
    logic [VALUE_BITS-1:0] radix_w;
    logic [VALUE_BITS-1:0] rem;
    logic [3:0]            d;
    text_char_t            c;
    int                    i;
    if (radix < BASE_MIN || radix > BASE_MAX) begin
      quot_state = '0;
      digit_total = 0;
      sign_flag = 1'b0;
      c = '{CHAR_NONE, 1'b1, 1'b1};
      expected_text.push_back(c);
      return;
    end
    radix_w = {{(VALUE_BITS-5){1'b0}}, radix};
    sign_flag = !uns && raw[VALUE_BITS-1];
    quot_state = sign_flag ? (~raw + 1'b1) : raw;  // most negative maps to 2^47 unsigned
    digit_total = 0;
    do begin
      if (digit_total < VALUE_BITS) begin
        rem = quot_state % radix_w;
        digit_mem[digit_total] = rem[3:0];
        digit_total++;
      end
      quot_state = quot_state / radix_w;
    end while (quot_state != '0);
    if (sign_flag) begin
      c = '{CHAR_MINUS, 1'b0, 1'b0};
      expected_text.push_back(c);
    end
    for (i = digit_total - 1; i >= 0; i--) begin
      d = digit_mem[i];
      if (d < 4'd10) c.code = CHAR_ZERO + {4'd0, d};
      else c.code = (lower ? CHAR_LO_A : CHAR_UP_A) + {4'd0, d - 4'd10};
      c.is_last = (i == 0);
      c.is_bad = 1'b0;
      expected_text.push_back(c);
    end
  endtask

  task automatic add_request(input logic [VALUE_BITS-1:0] v, input logic [4:0] b,
                             input bit uns, input bit lower, input bit drain);
    number_req_t r;
    r = '{v, b, uns, lower, phase_send, phase_recv, drain};
    pending_reqs.push_back(r);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [63:0]           wide;
    logic [VALUE_BITS-1:0] v;
    wide = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = wide[VALUE_BITS-1:0];
      1: v = VALUE_BITS'($urandom_range(1000));
      2: v = ~VALUE_BITS'($urandom_range(1000)) + 1'b1;
      default: v = wide[VALUE_BITS-1:0] >> $urandom_range(VALUE_BITS - 1);
    endcase
    return v;
  endfunction

  function automatic logic [4:0] random_bad_base();
    logic [4:0] b;
    b = 5'($urandom_range(31));
    while (b >= BASE_MIN && b <= BASE_MAX) b = 5'($urandom_range(31));
    return b;
  endfunction

  // driver: presents requests at the falling edge
  always @(negedge clk) begin : driver
    number_req_t r;
    bit          hold;
    hold = in_valid && !request_taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!hold) begin
      if (pending_reqs.size() != 0 &&
          $urandom_range(99) >= pending_reqs[0].send_idle &&
          (!pending_reqs[0].drain_first || (expected_text.size() == 0 && !in_valid))) begin
        r = pending_reqs.pop_front();
        value <= r.value;
        base <= r.base;
        unsigned_mode <= r.uns;
        lowercase <= r.lower;
        recv_idle_pct = r.recv_idle;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: checks characters and records requests at the rising edge
  always @(posedge clk) begin : monitor
    text_char_t want;
    request_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character: char_code %h last %b bad_base %b",
                 char_code, last, bad_base);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (char_code !== want.code) begin
            $error("char_code: expected %h, actual %h", want.code, char_code);
            fail_count++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %b, actual %b", want.is_last, last);
            fail_count++;
          end
          if (bad_base !== want.is_bad) begin
            $error("bad_base: expected %b, actual %b", want.is_bad, bad_base);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        request_taken = 1'b1;
        predict_text(value, base, unsigned_mode, lowercase);
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_BITS-1:0] most_neg;
    int                    n;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    value = '0;
    base = '0;
    unsigned_mode = 1'b0;
    lowercase = 1'b0;
    most_neg = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // directed: extremes, zero, most negative, bad bases, both letter cases
    add_request('0, 5'd10, 1'b0, 1'b0, 1'b0);
    add_request('0, 5'd2, 1'b1, 1'b1, 1'b0);
    add_request('1, 5'd2, 1'b1, 1'b0, 1'b0);
    add_request('1, 5'd16, 1'b1, 1'b1, 1'b0);
    add_request('1, 5'd16, 1'b1, 1'b0, 1'b0);
    add_request('1, 5'd16, 1'b0, 1'b0, 1'b0);
    add_request(most_neg, 5'd10, 1'b0, 1'b0, 1'b0);
    add_request(most_neg, 5'd2, 1'b0, 1'b1, 1'b0);
    add_request(most_neg, 5'd16, 1'b1, 1'b1, 1'b0);
    add_request(~most_neg, 5'd10, 1'b0, 1'b0, 1'b0);
    add_request(48'hABCDEF, 5'd16, 1'b0, 1'b1, 1'b0);
    add_request(48'hABCDEF, 5'd16, 1'b0, 1'b0, 1'b0);
    add_request(48'h0123456789AB, 5'd16, 1'b1, 1'b1, 1'b0);
    add_request(48'h1, 5'd2, 1'b0, 1'b0, 1'b0);
    add_request(48'd255, 5'd15, 1'b0, 1'b1, 1'b0);
    add_request(48'd1000000, 5'd3, 1'b0, 1'b0, 1'b0);
    add_request(48'd12345, 5'd7, 1'b1, 1'b0, 1'b0);
    add_request(48'd777, 5'd8, 1'b0, 1'b0, 1'b0);
    add_request(48'hFFFF_FFFF_FF00, 5'd13, 1'b0, 1'b1, 1'b0);
    add_request(48'd42, 5'd0, 1'b0, 1'b0, 1'b1);
    add_request('1, 5'd1, 1'b1, 1'b1, 1'b0);
    add_request(48'd99, 5'd17, 1'b0, 1'b0, 1'b0);
    add_request(48'h5A5A_5A5A_5A5A, 5'd31, 1'b1, 1'b0, 1'b0);
    add_request(48'd9, 5'd9, 1'b0, 1'b0, 1'b0);

    for (n = 0; n < 190; n++) begin
      if (n == 63) begin
        phase_send = 53;
        phase_recv = 31;
      end else if (n == 126) begin
        phase_send = 0;
        phase_recv = 0;
      end
      if ($urandom_range(99) < 15)
        add_request(random_value(), random_bad_base(), 1'($urandom), 1'($urandom),
                    n == 63 || n == 126 || $urandom_range(39) == 0);
      else
        add_request(random_value(), 5'($urandom_range(BASE_MAX, BASE_MIN)),
                    1'($urandom), 1'($urandom),
                    n == 63 || n == 126 || $urandom_range(39) == 0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_text.size() != 0) begin
      $error("%0d characters never arrived", expected_text.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rnt_pkg.sv
rtl/core/rnt_ram.sv
rtl/core/rnt_sequencer.sv
rtl/core/rnt_datapath.sv
rtl/core/radix_number_to_text.sv
tb/sv/radix_number_to_text_test.sv
